// ===== design/astd_pkg.sv =====
// ----------------------------------------------------------------------------
// astd_pkg: shared types and constants of the activation score throttle decider
// Field widths, register codes, throttle modes and the transaction structs.
// ----------------------------------------------------------------------------
package astd_pkg;

  localparam int MAX_CORES     = 4;
  localparam int NUM_CORES_DEF = 4;
  localparam int CORE_W        = 2;
  localparam int SCORE_W       = 16;
  localparam int FACTOR_W      = 16;
  localparam int FRAC_W        = 8;     // k is Q8.8
  localparam int FRAC_ONE      = 256;   // 1.0 in Q8.8
  localparam int STDEV_SHIFT   = 16;    // k^2 carries 16 fraction bits
  localparam int WINDOW_W      = 32;
  localparam int CFG_W         = 32;
  localparam int REG_IDX_W     = 2;
  localparam int PP_LO_W       = 32;    // split point of the wide product
  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [SCORE_W-1:0]  RST_FLAT   = 16'd512;
  localparam logic [FACTOR_W-1:0] RST_FACTOR = 16'd768;
  localparam logic [WINDOW_W-1:0] RST_WINDOW = 32'd102400000;

  typedef enum logic [1:0] {
    MODE_FLAT  = 2'd0,
    MODE_STDEV = 2'd1,
    MODE_MEAN  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_FLAT   = 2'd1,
    REG_FACTOR = 2'd2,
    REG_WINDOW = 2'd3
  } reg_index_t;

  typedef struct packed {
    mode_t                mode;
    logic [SCORE_W-1:0]   flat;
    logic [FACTOR_W-1:0]  factor;
    logic [WINDOW_W-1:0]  window;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic               source_valid;
    logic [CORE_W-1:0]  source_core;
    logic [SCORE_W-1:0] score_core0;
    logic [SCORE_W-1:0] score_core1;
    logic [SCORE_W-1:0] score_core2;
    logic [SCORE_W-1:0] score_core3;
  } item_t;

  typedef struct packed {
    logic                 window_end;
    logic [MAX_CORES-1:0] released_mask;
    logic                 act_notify_valid;
    logic [CORE_W-1:0]    act_notify_core;
    logic [MAX_CORES-1:0] new_throttle_mask;
    logic [MAX_CORES-1:0] throttled_mask;
    logic                 first_throttle;
  } result_t;

  typedef struct packed {
    logic              command;
    logic              source_valid;
    logic [CORE_W-1:0] source_core;
    logic              wrap;
  } ctrl_t;

  // Classified tick handed from front to back.
  typedef struct packed {
    ctrl_t                ctrl;
    logic [MAX_CORES-1:0] cand;
  } cls_t;

endpackage

// ===== design/astd_fifo.sv =====
// ----------------------------------------------------------------------------
// astd_fifo: small synchronous queue
// Register-based, first word fall-through; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module astd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== design/astd_front.sv =====
// ----------------------------------------------------------------------------
// astd_front: window counting and per-core throttle classification
// Six-stage pipeline; yields a candidate mask per tick, ignoring flags.
// ----------------------------------------------------------------------------
module astd_front #(
  parameter int NUM_CORES = astd_pkg::NUM_CORES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  astd_pkg::cfg_t  cfg,
  input  logic            push,
  input  astd_pkg::item_t item,
  output logic            full,
  output logic            cls_push,
  output astd_pkg::cls_t  cls,
  input  logic            cls_full
);

  localparam int LOG_N    = $clog2(NUM_CORES);
  localparam int SCORE_W  = astd_pkg::SCORE_W;
  localparam int SQ_W     = 2 * SCORE_W;
  localparam int SUM_W    = SCORE_W + LOG_N;
  localparam int Q_W      = SQ_W + LOG_N;
  localparam int NV_W     = 2 * SUM_W;
  localparam int NNV_W    = NV_W + LOG_N;
  localparam int KK_W     = 2 * astd_pkg::FACTOR_W;
  localparam int LO_W     = astd_pkg::PP_LO_W;
  localparam int PLO_W    = KK_W + LO_W;
  localparam int PHI_W    = KK_W + NNV_W - LO_W;
  localparam int RHS_W    = KK_W + NNV_W;
  localparam int DSQ_W    = 2 * SUM_W;
  localparam int LHS_W    = DSQ_W + astd_pkg::STDEV_SHIFT + LOG_N;
  localparam int ML_W     = SUM_W + astd_pkg::FRAC_W;
  localparam int MR_W     = SUM_W + astd_pkg::FACTOR_W + 1;
  localparam int WIN_W    = astd_pkg::WINDOW_W;

  function automatic logic [SCORE_W-1:0] score_of(input astd_pkg::item_t it,
                                                  input int unsigned idx);
    case (idx)
      0:       return it.score_core0;
      1:       return it.score_core1;
      2:       return it.score_core2;
      default: return it.score_core3;
    endcase
  endfunction

  // window counter, updated at accept
  logic [WIN_W-1:0] window_tick;
  logic [WIN_W:0]   tick_inc;
  logic             wrap;
  logic             accept;
  logic             adv;
  logic [5:0]       vld;

  assign tick_inc = {1'b0, window_tick} + (WIN_W+1)'(1);
  assign wrap     = (tick_inc >= {1'b0, cfg.window});
  assign adv      = !(vld[5] && cls_full);
  assign full     = !adv;
  assign accept   = push && !full;
  assign cls_push = vld[5] && !cls_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_tick <= '0;
      vld         <= '0;
    end else begin
      if (accept) begin
        window_tick <= wrap ? '0 : tick_inc[WIN_W-1:0];
      end
      if (adv) begin
        vld <= {vld[4:0], accept};
      end
    end
  end

  // pipeline payload
  astd_pkg::ctrl_t ctrl0, ctrl1, ctrl2, ctrl3, ctrl4, ctrl5;
  logic [SCORE_W-1:0]   s0   [NUM_CORES];
  logic [SUM_W-1:0]     sum1;
  logic [SQ_W-1:0]      sq1  [NUM_CORES];
  logic [SUM_W-1:0]     ns1  [NUM_CORES];
  logic [KK_W-1:0]      kk1, kk2, kk3, kk4;
  logic [NUM_CORES-1:0] ge1, ge2, ge3, ge4, ge5;
  logic [Q_W-1:0]       q2;
  logic [NV_W-1:0]      ssq2;
  logic [SUM_W-1:0]     d2   [NUM_CORES];
  logic [NUM_CORES-1:0] dp2, dp3, dp4, dp5;
  logic [MR_W-1:0]      mr2;
  logic [ML_W-1:0]      ml2  [NUM_CORES];
  logic [NV_W-1:0]      nv3;
  logic [DSQ_W-1:0]     dsq3 [NUM_CORES];
  logic [NUM_CORES-1:0] mh3, mh4, mh5;
  logic [NNV_W-1:0]     nnv4;
  logic [LHS_W-1:0]     lhs4 [NUM_CORES];
  logic [LHS_W-1:0]     lhs5 [NUM_CORES];
  logic [PLO_W-1:0]     plo5;
  logic [PHI_W-1:0]     phi5;

  logic [SUM_W-1:0]     sum_next;
  logic [Q_W-1:0]       q_next;
  logic [RHS_W-1:0]     rhs;
  logic [NUM_CORES-1:0] sd_hit;
  logic [NUM_CORES-1:0] cand;

  always_comb begin
    sum_next = '0;
    q_next   = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      sum_next = sum_next + SUM_W'(s0[i]);
      q_next   = q_next + Q_W'(sq1[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 0: capture
      ctrl0.command      <= item.command;
      ctrl0.source_valid <= item.source_valid;
      ctrl0.source_core  <= item.source_core;
      ctrl0.wrap         <= wrap;
      for (int i = 0; i < NUM_CORES; i++) begin
        s0[i] <= score_of(item, i);
      end
      // stage 1: sum, squares, N*s, k^2, flat compare
      ctrl1 <= ctrl0;
      sum1  <= sum_next;
      kk1   <= KK_W'(cfg.factor) * KK_W'(cfg.factor);
      for (int i = 0; i < NUM_CORES; i++) begin
        sq1[i] <= SQ_W'(s0[i]) * SQ_W'(s0[i]);
        ns1[i] <= SUM_W'(s0[i]) * SUM_W'(NUM_CORES);
        ge1[i] <= (s0[i] >= cfg.flat);
      end
      // stage 2: sum of squares, S^2, deviations, mean threshold
      ctrl2 <= ctrl1;
      q2    <= q_next;
      ssq2  <= NV_W'(sum1) * NV_W'(sum1);
      mr2   <= MR_W'(sum1) * (MR_W'(cfg.factor) + MR_W'(astd_pkg::FRAC_ONE));
      kk2   <= kk1;
      ge2   <= ge1;
      for (int i = 0; i < NUM_CORES; i++) begin
        d2[i]  <= ns1[i] - sum1;
        dp2[i] <= (ns1[i] >= sum1);
        ml2[i] <= ML_W'(ns1[i]) << astd_pkg::FRAC_W;
      end
      // stage 3: N*Q - S^2, D^2, mean test
      ctrl3 <= ctrl2;
      nv3   <= NV_W'(q2) * NV_W'(NUM_CORES) - ssq2;
      kk3   <= kk2;
      ge3   <= ge2;
      dp3   <= dp2;
      for (int i = 0; i < NUM_CORES; i++) begin
        dsq3[i] <= DSQ_W'(d2[i]) * DSQ_W'(d2[i]);
        mh3[i]  <= (MR_W'(ml2[i]) >= mr2);
      end
      // stage 4: N*variance term, scaled D^2
      ctrl4 <= ctrl3;
      nnv4  <= NNV_W'(nv3) * NNV_W'(NUM_CORES);
      kk4   <= kk3;
      ge4   <= ge3;
      dp4   <= dp3;
      mh4   <= mh3;
      for (int i = 0; i < NUM_CORES; i++) begin
        lhs4[i] <= (LHS_W'(dsq3[i]) * LHS_W'(NUM_CORES - 1)) << astd_pkg::STDEV_SHIFT;
      end
      // stage 5: k^2 * N*nv as two partial products
      ctrl5 <= ctrl4;
      plo5  <= PLO_W'(kk4) * PLO_W'(nnv4[LO_W-1:0]);
      phi5  <= PHI_W'(kk4) * PHI_W'(nnv4[NNV_W-1:LO_W]);
      ge5   <= ge4;
      dp5   <= dp4;
      mh5   <= mh4;
      for (int i = 0; i < NUM_CORES; i++) begin
        lhs5[i] <= lhs4[i];
      end
    end
  end

  always_comb begin
    rhs = RHS_W'(plo5) + (RHS_W'(phi5) << LO_W);
    for (int i = 0; i < NUM_CORES; i++) begin
      sd_hit[i] = (RHS_W'(lhs5[i]) >= rhs);
    end
    case (cfg.mode)
      astd_pkg::MODE_FLAT:  cand = ge5;
      astd_pkg::MODE_MEAN:  cand = ge5 & mh5;
      astd_pkg::MODE_STDEV: cand = ge5 & dp5 & sd_hit;
      default:              cand = '0;
    endcase
    cls.ctrl = ctrl5;
    cls.cand = astd_pkg::MAX_CORES'(cand);
  end

endmodule

// ===== design/astd_back.sv =====
// ----------------------------------------------------------------------------
// astd_back: throttle flag keeper
// Applies window release and candidate masks to the per-core flags.
// ----------------------------------------------------------------------------
module astd_back #(
  parameter int NUM_CORES = astd_pkg::NUM_CORES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  astd_pkg::mode_t   mode,
  input  logic              cls_empty,
  input  astd_pkg::cls_t    cls,
  output logic              cls_pop,
  input  logic              res_full,
  output logic              res_push,
  output astd_pkg::result_t res
);

  localparam int CW = astd_pkg::CORE_W;
  localparam int MC = astd_pkg::MAX_CORES;

  logic [NUM_CORES-1:0] flags;
  logic [NUM_CORES-1:0] flags_next;
  logic [NUM_CORES-1:0] kept;
  logic [NUM_CORES-1:0] new_mask;
  logic                 seen;
  logic                 first;
  logic                 go;
  logic                 active;
  logic                 act;
  logic                 src_ok;
  logic                 win_end;

  always_comb begin
    go       = !cls_empty && !res_full;
    cls_pop  = go;
    res_push = go;
    active   = (mode != astd_pkg::MODE_NONE);
    win_end  = active && cls.ctrl.wrap;
    act      = active && cls.ctrl.command;
    kept     = cls.ctrl.wrap ? '0 : flags;
    new_mask = act ? (cls.cand[NUM_CORES-1:0] & ~kept) : '0;
    src_ok   = cls.ctrl.source_valid &&
               ({1'b0, cls.ctrl.source_core} < (CW+1)'(NUM_CORES));
    flags_next = active ? (kept | new_mask) : flags;
    first    = act && (new_mask != '0) && !seen;

    res.window_end        = win_end;
    res.released_mask     = win_end ? MC'(flags) : '0;
    res.act_notify_valid  = act && src_ok;
    res.act_notify_core   = (act && src_ok) ? cls.ctrl.source_core : '0;
    res.new_throttle_mask = MC'(new_mask);
    res.throttled_mask    = MC'(flags_next);
    res.first_throttle    = first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      seen  <= 1'b0;
    end else if (go) begin
      flags <= flags_next;
      seen  <= seen | first;
    end
  end

endmodule

// ===== design/activation_score_throttle_decider_core.sv =====
// ----------------------------------------------------------------------------
// activation_score_throttle_decider_core: per-tick core throttling decisions
// Path: a transaction passes the six front stages and the middle queue; the
// back step is combinational and writes the result into the result queue.
// Throughput: one transaction per cycle, set by the fully pipelined front, unless the result side stalls.
// Reset (synchronous, rst high) empties both queues and the front pipeline,
// clears window counter, throttle flags and first-throttle mark, and loads
// the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module activation_score_throttle_decider_core #(
  parameter int NUM_CORES = astd_pkg::NUM_CORES_DEF,
  parameter int MID_DEPTH = astd_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = astd_pkg::OUT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [astd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [astd_pkg::CFG_W-1:0]        cfg_data,
  // input queue side
  input  logic                              push,
  input  astd_pkg::item_t                   item,
  output logic                              full,
  // result queue side
  output logic                              empty,
  input  logic                              pop,
  output astd_pkg::result_t                 result
);

  // Configuration registers. The user must write them only while the block is idle; the
  // block does not enforce this. The front and back read them directly without shadowing.
  astd_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= astd_pkg::MODE_STDEV;
      cfg.flat   <= astd_pkg::RST_FLAT;
      cfg.factor <= astd_pkg::RST_FACTOR;
      cfg.window <= astd_pkg::RST_WINDOW;
    end else if (cfg_we) begin
      case (cfg_index)
        astd_pkg::REG_MODE:   cfg.mode   <= astd_pkg::mode_t'(cfg_data[1:0]);
        astd_pkg::REG_FLAT:   cfg.flat   <= cfg_data[astd_pkg::SCORE_W-1:0];
        astd_pkg::REG_FACTOR: cfg.factor <= cfg_data[astd_pkg::FACTOR_W-1:0];
        astd_pkg::REG_WINDOW: cfg.window <= cfg_data[astd_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: counts the window on every accepted transaction and works out,
  // per core, whether the selected mode would throttle it. The result does
  // not depend on the throttle flags, which lets the front run ahead.
  logic           cls_push;
  logic           cls_full;
  astd_pkg::cls_t cls_wr;

  astd_front #(
    .NUM_CORES (NUM_CORES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .item     (item),
    .full     (full),
    .cls_push (cls_push),
    .cls      (cls_wr),
    .cls_full (cls_full)
  );

  // Short queue that decouples the front pipeline from the back.
  logic           cls_pop;
  logic           cls_empty;
  astd_pkg::cls_t cls_rd;

  astd_fifo #(
    .WIDTH ($bits(astd_pkg::cls_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cls_push),
    .wr_data (cls_wr),
    .full    (cls_full),
    .rd_en   (cls_pop),
    .rd_data (cls_rd),
    .empty   (cls_empty)
  );

  // Back: owns the throttle flags; release at window end happens before the
  // candidates of the same tick are applied.
  logic              res_push;
  logic              res_full;
  astd_pkg::result_t res_wr;

  astd_back #(
    .NUM_CORES (NUM_CORES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .mode      (cfg.mode),
    .cls_empty (cls_empty),
    .cls       (cls_rd),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_wr)
  );

  // Result queue: the oldest result is shown while empty is low.
  astd_fifo #(
    .WIDTH ($bits(astd_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

`ifndef SYNTH
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not idle after reset");

  a_new_is_throttled: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((result.new_throttle_mask & ~result.throttled_mask) == '0))
    else $error("newly throttled core missing from throttled mask");

  a_first_has_new: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.first_throttle) |-> (result.new_throttle_mask != '0))
    else $error("first throttle without a new throttle");

  a_release_at_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.released_mask != '0)) |-> result.window_end)
    else $error("release outside a window end");
`endif

endmodule
